[design/lfdt_pkg.sv]
// Shared constants, codes and types of the lowest free descriptor table.
package lfdt_pkg;

   localparam int LOWEST_DESCRIPTOR  = 3;
   localparam int HIGHEST_DESCRIPTOR = 127;
   localparam int HANDLE_BITS        = 32;

   localparam int MODE_W   = 2;
   localparam int DESC_W   = 7;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 2;

   // Slots are grouped by eight for the two-level free search.
   localparam int GROUP_LSB  = 3;
   localparam int GROUP_SIZE = 1 << GROUP_LSB;
   localparam int SLOT_BITS  = ($clog2(HIGHEST_DESCRIPTOR + 1) > GROUP_LSB + 1) ?
                               $clog2(HIGHEST_DESCRIPTOR + 1) : GROUP_LSB + 1;
   localparam int NUM_SLOTS  = 1 << SLOT_BITS;
   localparam int GROUP_BITS = SLOT_BITS - GROUP_LSB;
   localparam int NUM_GROUPS = 1 << GROUP_BITS;

   localparam logic [MODE_W-1:0] MODE_ALLOCATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic apply;
   } cmd_type;

   function automatic logic [NUM_SLOTS-1:0] range_mask();
      logic [NUM_SLOTS-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         m[i] = (i >= LOWEST_DESCRIPTOR) && (i <= HIGHEST_DESCRIPTOR);
      end
      return m;
   endfunction

   localparam logic [NUM_SLOTS-1:0] RANGE_MASK = range_mask();

endpackage

[design/lowest_free_descriptor_table.sv]
// Lowest free descriptor table: allocate, lookup and release of descriptors.
// Each request passes capture, scan and apply in turn before its response is valid.
// A new request is taken only in idle, after the last one has left apply; it is taken
// while an earlier response beat may still wait, and apply holds until that beat is taken.
// The free search runs as a registered group level and a slot level in apply.
// Reset clears all in-use marks at once; handle memory is not cleared.
module lowest_free_descriptor_table import lfdt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // descriptor [6:0], bind_handle [38:7], zero [39]
   input  logic [1:0]  req_tuser,   // mode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // granted_descriptor [6:0], found_handle [38:7], zero [39]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   cmd_type             cmd;
   logic [STATUS_W-1:0] status;
   logic [DESC_W-1:0]   granted;
   logic [HANDLE_W-1:0] found;

   lfdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lfdt_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .req_mode               (req_tuser),
      .req_descriptor         (req_tdata[6:0]),
      .req_bind_handle        (req_tdata[38:7]),
      .rsp_status             (status),
      .rsp_granted_descriptor (granted),
      .rsp_found_handle       (found)
   );

   assign rsp_tdata = {1'b0, found, granted};
   assign rsp_tuser = status;

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STATUS_OK || rsp_tuser == STATUS_BAD ||
                     rsp_tuser == STATUS_FULL)
      else $error("undefined status code");

   a_grant_no_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6:0] != 7'd0 |-> rsp_tuser == STATUS_OK && rsp_tdata[38:7] == 32'd0)
      else $error("grant beat carries a handle or a failing status");

   a_full_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[38:0] == 39'd0)
      else $error("failing response carries data");

endmodule

[design/lfdt_ctrl.sv]
// Controller state machine of the lowest free descriptor table.
module lfdt_ctrl import lfdt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[design/lfdt_datapath.sv]
// Datapath: in-use marks, handle memory, lowest free search and result register.
module lfdt_datapath import lfdt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [DESC_W-1:0]   req_descriptor,
   input  logic [HANDLE_W-1:0] req_bind_handle,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [DESC_W-1:0]   rsp_granted_descriptor,
   output logic [HANDLE_W-1:0] rsp_found_handle
);

   logic [HANDLE_BITS-1:0] handle_mem [NUM_SLOTS];

   logic [MODE_W-1:0]      mode_ff;
   logic [DESC_W-1:0]      desc_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [NUM_SLOTS-1:0]   in_use_ff, in_use_in;
   logic [NUM_GROUPS-1:0]  group_free_ff;
   logic [HANDLE_BITS-1:0] rd_ff;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [DESC_W-1:0]      granted_ff, granted_in;
   logic [HANDLE_W-1:0]    found_ff, found_in;

   logic [NUM_SLOTS-1:0]   free_mask;
   logic [NUM_GROUPS-1:0]  group_free_in;
   logic                   grp_hit;
   logic [GROUP_BITS-1:0]  grp_sel;
   logic [GROUP_SIZE-1:0]  grp_bits;
   logic [GROUP_LSB-1:0]   bit_sel;
   logic [SLOT_BITS-1:0]   alloc_idx;
   logic [SLOT_BITS-1:0]   desc_slot;
   logic                   desc_ok;
   logic                   do_write;

   assign free_mask = ~in_use_ff & RANGE_MASK;
   assign desc_slot = SLOT_BITS'(desc_ff);
   assign desc_ok   = (int'(desc_ff) >= LOWEST_DESCRIPTOR) &&
                      (int'(desc_ff) <= HIGHEST_DESCRIPTOR) && in_use_ff[desc_slot];

   // first level: one free flag per group of eight slots
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_free_in[g] = |free_mask[g*GROUP_SIZE +: GROUP_SIZE];
      end
   end

   // second level: lowest free group, then lowest free slot inside it
   always_comb begin
      grp_hit = 1'b0;
      grp_sel = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (group_free_ff[g]) begin
            grp_hit = 1'b1;
            grp_sel = GROUP_BITS'(g);
         end
      end
      grp_bits = free_mask[{grp_sel, {GROUP_LSB{1'b0}}} +: GROUP_SIZE];
      bit_sel  = '0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            bit_sel = GROUP_LSB'(b);
         end
      end
      alloc_idx = {grp_sel, bit_sel};
   end

   always_comb begin
      in_use_in  = in_use_ff;
      status_in  = STATUS_BAD;
      granted_in = '0;
      found_in   = '0;
      do_write   = 1'b0;
      unique case (mode_ff)
         MODE_ALLOCATE: begin
            if (grp_hit) begin
               status_in            = STATUS_OK;
               granted_in           = DESC_W'(alloc_idx);
               in_use_in[alloc_idx] = 1'b1;
               do_write             = 1'b1;
            end else begin
               status_in = STATUS_FULL;
            end
         end
         MODE_LOOKUP, MODE_RELEASE: begin
            if (desc_ok) begin
               status_in = STATUS_OK;
               found_in  = HANDLE_W'(rd_ff);
               if (mode_ff == MODE_RELEASE) begin
                  in_use_in[desc_slot] = 1'b0;
               end
            end
         end
         default: status_in = STATUS_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else if (cmd.apply) begin
         in_use_ff <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_mode;
         desc_ff   <= req_descriptor;
         handle_ff <= HANDLE_BITS'(req_bind_handle);
      end
      if (cmd.scan) begin
         group_free_ff <= group_free_in;
         rd_ff         <= handle_mem[desc_slot];
      end
      if (cmd.apply) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply && do_write) begin
         handle_mem[alloc_idx] <= handle_ff;
      end
   end

   assign rsp_status             = status_ff;
   assign rsp_granted_descriptor = granted_ff;
   assign rsp_found_handle       = found_ff;

endmodule

[dv/testbench.sv]
// Self-checking bench for the lowest free descriptor table: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module testbench;
   import lfdt_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_ITEMS = 100;
   localparam int PHASE_COUNT = 14;

   typedef enum {PH_FILL, PH_MIXED, PH_DRAIN} churn_type;

   // Tracks the table contents and the responses still owed by the block.
   class descriptor_scoreboard;
      typedef struct packed {
         logic [STATUS_W-1:0] status;
         logic [DESC_W-1:0]   granted;
         logic [HANDLE_W-1:0] handle;
      } outcome_type;

      bit                  in_use [256];
      logic [HANDLE_W-1:0] bound [256];
      outcome_type         awaited [$];
      int                  errors;

      function new();
         for (int i = 0; i < 256; i++) begin
            in_use[i] = 1'b0;
            bound[i]  = '0;
         end
         errors = 0;
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [DESC_W-1:0] desc,
                                 logic [HANDLE_W-1:0] handle);
         outcome_type o;
         logic [63:0] hmask;
         int slot;
         bit done;
         hmask = {64{1'b1}} >> (64 - HANDLE_BITS);
         o = '{status: STATUS_BAD, granted: '0, handle: '0};
         done = 1'b0;
         if (mode == MODE_ALLOCATE) begin
            o.status = STATUS_FULL;
            for (int i = LOWEST_DESCRIPTOR; i <= HIGHEST_DESCRIPTOR; i++) begin
               slot = i & 8'hFF;
               if (!done && !in_use[slot]) begin
                  bound[slot]  = handle & hmask[HANDLE_W-1:0];
                  in_use[slot] = 1'b1;
                  o.status  = STATUS_OK;
                  o.granted = i[DESC_W-1:0];
                  done = 1'b1;
               end
            end
         end else if (mode == MODE_LOOKUP || mode == MODE_RELEASE) begin
            slot = int'(desc);
            if (slot >= LOWEST_DESCRIPTOR && slot <= HIGHEST_DESCRIPTOR && in_use[slot]) begin
               if (mode == MODE_RELEASE)
                  in_use[slot] = 1'b0;
               o.status = STATUS_OK;
               o.handle = bound[slot];
            end
         end
         awaited.push_back(o);
      endfunction

      task report_mismatch(string what, logic [HANDLE_W-1:0] want, logic [HANDLE_W-1:0] got);
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         errors++;
      endtask

      task check_response(logic [STATUS_W-1:0] status, logic [DESC_W-1:0] granted,
                          logic [HANDLE_W-1:0] handle);
         outcome_type o;
         if (awaited.size() == 0) begin
            report_mismatch("unexpected beat", '0, HANDLE_W'({granted, status}));
         end else begin
            o = awaited.pop_front();
            if (status !== o.status)
               report_mismatch("status", HANDLE_W'(o.status), HANDLE_W'(status));
            if (granted !== o.granted)
               report_mismatch("granted_descriptor", HANDLE_W'(o.granted), HANDLE_W'(granted));
            if (handle !== o.handle)
               report_mismatch("found_handle", o.handle, handle);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // descriptor [6:0], bind_handle [38:7], zero [39]
   logic [1:0]  req_tuser = '0;   // mode [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // granted_descriptor [6:0], found_handle [38:7], zero [39]
   logic [1:0]  rsp_tuser;        // status [1:0]

   descriptor_scoreboard sb;
   bit calm = 1'b0;   // both sides skip their random idle gaps while set

   lowest_free_descriptor_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   initial begin
      #4_000_000;
      $display("lowest_free_descriptor_table regression: fail");
      $finish;
   end

   task send_request(input logic [MODE_W-1:0] mode, input logic [DESC_W-1:0] desc,
                     input logic [HANDLE_W-1:0] handle);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, handle, desc};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(mode, desc, handle);
   endtask

   // Prefer a descriptor that is currently bound, so lookups and releases hit.
   function automatic logic [DESC_W-1:0] live_descriptor();
      int start;
      int idx;
      start = $urandom_range(0, 127);
      for (int k = 0; k < 128; k++) begin
         idx = (start + k) % 128;
         if (sb.in_use[idx])
            return idx[DESC_W-1:0];
      end
      return start[DESC_W-1:0];
   endfunction

   task random_request(input churn_type kind);
      int roll;
      int alloc_cut, lookup_cut, release_cut;
      logic [MODE_W-1:0]   mode;
      logic [DESC_W-1:0]   desc;
      logic [HANDLE_W-1:0] handle;
      case (kind)
         PH_FILL:  begin alloc_cut = 80; lookup_cut = 90; release_cut = 96; end
         PH_DRAIN: begin alloc_cut = 12; lookup_cut = 32; release_cut = 95; end
         default:  begin alloc_cut = 35; lookup_cut = 65; release_cut = 95; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < alloc_cut)        mode = MODE_ALLOCATE;
      else if (roll < lookup_cut)  mode = MODE_LOOKUP;
      else if (roll < release_cut) mode = MODE_RELEASE;
      else                         mode = MODE_UNUSED;
      case ($urandom_range(0, 9))
         0:       handle = '0;
         1:       handle = '1;
         default: handle = $urandom;
      endcase
      if ((mode == MODE_LOOKUP || mode == MODE_RELEASE) && $urandom_range(0, 3) != 0)
         desc = live_descriptor();
      else
         desc = DESC_W'($urandom_range(0, 127));
      send_request(mode, desc, handle);
   endtask

   // Response side: random stalls, plus two long holds to back up the block.
   initial begin
      int stall;
      int beats;
      beats = 0;
      while (reset) @(posedge clock);
      forever begin
         if (beats == 300 || beats == 900)
            stall = LONG_HOLD;
         else
            stall = calm ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_response(rsp_tuser, rsp_tdata[6:0], rsp_tdata[38:7]);
         beats++;
      end
   end

   initial begin
      churn_type pattern [7];
      sb = new();
      pattern = '{PH_FILL, PH_FILL, PH_MIXED, PH_DRAIN, PH_DRAIN, PH_MIXED, PH_FILL};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: range edges, unbound numbers, the unused mode, reuse of a freed number.
      send_request(MODE_LOOKUP,   7'd0,   32'h0000_0000);
      send_request(MODE_RELEASE,  7'd127, 32'h0000_0000);
      send_request(MODE_UNUSED,   7'h7F,  32'hFFFF_FFFF);
      send_request(MODE_ALLOCATE, 7'h7F,  32'h0000_0000);
      send_request(MODE_ALLOCATE, 7'd0,   32'hFFFF_FFFF);
      send_request(MODE_ALLOCATE, 7'd55,  32'hA5A5_5A5A);
      send_request(MODE_LOOKUP,   7'd3,   32'hFFFF_FFFF);
      send_request(MODE_LOOKUP,   7'd4,   32'h0000_0000);
      send_request(MODE_LOOKUP,   7'd2,   32'h0000_0000);
      send_request(MODE_RELEASE,  7'd4,   32'h0000_0000);
      send_request(MODE_LOOKUP,   7'd4,   32'h0000_0000);
      send_request(MODE_ALLOCATE, 7'd9,   32'h1234_5678);
      send_request(MODE_LOOKUP,   7'd5,   32'h0000_0000);
      send_request(MODE_RELEASE,  7'd3,   32'h0000_0000);
      send_request(MODE_RELEASE,  7'd3,   32'h0000_0000);
      send_request(MODE_UNUSED,   7'd0,   32'h0000_0000);
      send_request(MODE_LOOKUP,   7'd127, 32'h0000_0000);
      send_request(MODE_RELEASE,  7'd0,   32'h0000_0000);

      // Random: fill to full, churn, drain, churn, fill again; the pattern repeats.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         calm = (p % 4 == 3);
         for (int n = 0; n < PHASE_ITEMS; n++)
            random_request(pattern[p % 7]);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("lowest_free_descriptor_table regression: pass");
      else
         $display("lowest_free_descriptor_table regression: fail");
      $finish;
   end

endmodule

[filelist.f]
design/lfdt_pkg.sv
design/lfdt_ctrl.sv
design/lfdt_datapath.sv
design/lowest_free_descriptor_table.sv
dv/testbench.sv
